>>> design/pw_pkg.sv
// Shared types and constants for the perspective image warp unit.
// No dependencies; every other design file imports this package.
`default_nettype none
package pw_pkg;

    localparam int NUM_CFG   = 7;
    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;

    // Configuration register indexes.
    localparam int REG_W_COL   = 0;
    localparam int REG_W_ROW   = 1;
    localparam int REG_W_CONST = 2;
    localparam int REG_X_COL   = 3;
    localparam int REG_X_ROW   = 4;
    localparam int REG_Y_COL   = 5;
    localparam int REG_Y_ROW   = 6;

    localparam logic [2:0] IDX_W_COL   = 3'd0;
    localparam logic [2:0] IDX_W_ROW   = 3'd1;
    localparam logic [2:0] IDX_W_CONST = 3'd2;
    localparam logic [2:0] IDX_X_COL   = 3'd3;
    localparam logic [2:0] IDX_X_ROW   = 3'd4;
    localparam logic [2:0] IDX_Y_COL   = 3'd5;
    localparam logic [2:0] IDX_Y_ROW   = 3'd6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t COEF_ZERO = 32'sh0000_0000;
    localparam coef_t COEF_ONE  = 32'sh4000_0000;

    typedef struct packed {
        logic valid;
        logic op;
    } ctl_t;

endpackage
`default_nettype wire

>>> design/pw_mac.sv
// Three-stage multiply and accumulate that forms the w, x and y sums.
// Depends on pw_pkg; the outputs feed the divider pipeline in pw_div.
`default_nettype none
module pw_mac #(
    parameter int JW = 9,
    parameter int SW = 8,
    parameter int PW = 43
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  pw_pkg::ctl_t           ctl_in,
    input  logic [SW-1:0]          side_in,
    input  logic signed [JW-1:0]   j,
    input  logic signed [JW-1:0]   i,
    input  pw_pkg::coef_t          coef [pw_pkg::NUM_CFG],
    output pw_pkg::ctl_t           ctl_out,
    output logic [SW-1:0]          side_out,
    output logic [PW-1:0]          w_mag,
    output logic [PW-1:0]          x_mag,
    output logic [PW-1:0]          y_mag,
    output logic                   w_zero,
    output logic                   x_neg,
    output logic                   y_neg
);
    import pw_pkg::*;

    localparam int MW = COEF_W + JW;

    logic signed [MW-1:0] prod_reg  [6];
    logic signed [MW-1:0] prod_next [6];
    coef_t                wc_reg;
    logic signed [PW-1:0] w_reg, x_reg, y_reg;
    logic signed [PW-1:0] w_next, x_next, y_next;
    ctl_t                 ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic [SW-1:0]        side_a_reg, side_b_reg, side_c_reg;
    logic [PW-1:0]        w_mag_reg, x_mag_reg, y_mag_reg;
    logic                 w_zero_reg, x_neg_reg, y_neg_reg;

    always_comb begin
        prod_next[0] = MW'(coef[REG_W_COL]) * MW'(j);
        prod_next[1] = MW'(coef[REG_W_ROW]) * MW'(i);
        prod_next[2] = MW'(coef[REG_X_COL]) * MW'(j);
        prod_next[3] = MW'(coef[REG_X_ROW]) * MW'(i);
        prod_next[4] = MW'(coef[REG_Y_COL]) * MW'(j);
        prod_next[5] = MW'(coef[REG_Y_ROW]) * MW'(i);
        w_next = PW'(prod_reg[0]) + PW'(prod_reg[1]) + PW'(wc_reg);
        x_next = PW'(prod_reg[2]) + PW'(prod_reg[3]);
        y_next = PW'(prod_reg[4]) + PW'(prod_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else if (adv) begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= prod_next;
            wc_reg     <= coef[REG_W_CONST];
            side_a_reg <= side_in;
            w_reg      <= w_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            side_b_reg <= side_a_reg;
            // Magnitudes and quotient signs for the unsigned divider.
            w_mag_reg  <= w_reg[PW-1] ? PW'(-w_reg) : PW'(w_reg);
            x_mag_reg  <= x_reg[PW-1] ? PW'(-x_reg) : PW'(x_reg);
            y_mag_reg  <= y_reg[PW-1] ? PW'(-y_reg) : PW'(y_reg);
            w_zero_reg <= (w_reg == '0);
            x_neg_reg  <= x_reg[PW-1] ^ w_reg[PW-1];
            y_neg_reg  <= y_reg[PW-1] ^ w_reg[PW-1];
            side_c_reg <= side_b_reg;
        end
    end

    assign ctl_out  = ctl_c_reg;
    assign side_out = side_c_reg;
    assign w_mag    = w_mag_reg;
    assign x_mag    = x_mag_reg;
    assign y_mag    = y_mag_reg;
    assign w_zero   = w_zero_reg;
    assign x_neg    = x_neg_reg;
    assign y_neg    = y_neg_reg;

endmodule
`default_nettype wire

>>> design/pw_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the x and y lanes.
// Depends on pw_pkg; maps both quotients to source offsets and a hit flag.
`default_nettype none
module pw_div #(
    parameter int PW     = 43,
    parameter int DB     = 6,
    parameter int HALF_X = 64,
    parameter int HALF_Y = 64,
    parameter int OW_X   = 7,
    parameter int OW_Y   = 7,
    parameter int SW     = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  pw_pkg::ctl_t     ctl_in,
    input  logic [SW-1:0]    side_in,
    input  logic [PW-1:0]    w_mag,
    input  logic [PW-1:0]    x_mag,
    input  logic [PW-1:0]    y_mag,
    input  logic             w_zero,
    input  logic             x_neg,
    input  logic             y_neg,
    output pw_pkg::ctl_t     ctl_out,
    output logic [SW-1:0]    side_out,
    output logic             hit,
    output logic [OW_X-1:0]  col_src,
    output logic [OW_Y-1:0]  row_src
);
    import pw_pkg::*;

    localparam int RW = PW + DB;
    localparam int ZW = PW + FRAC_BITS;

    ctl_t          ctl_reg  [DB+1];
    logic [SW-1:0] side_reg [DB+1];
    logic [PW-1:0] den_reg  [DB+1];
    logic          wz_reg   [DB+1];
    logic [RW-1:0] rem_reg  [DB+1][2];
    logic [DB-1:0] q_reg    [DB+1][2];
    logic          fits_reg [DB+1][2];
    logic          neg_reg  [DB+1][2];

    ctl_t          ctl_o_reg;
    logic [SW-1:0] side_o_reg;
    logic          hit_reg;
    logic [OW_X-1:0] col_reg;
    logic [OW_Y-1:0] row_reg;
    logic [DB-1:0] kx, ky;
    logic          in_x, in_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DB; s++) begin
                ctl_reg[s] <= '0;
            end
            ctl_o_reg <= '0;
        end else if (adv) begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s <= DB; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            ctl_o_reg <= ctl_reg[DB];
        end
    end

    // Entry stage: the quotient fits in DB bits only if a < b * 2^DB.
    // A quotient that rounds to zero maps to index minus one, as a negative one does.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0]    <= side_in;
            den_reg[0]     <= w_mag;
            wz_reg[0]      <= w_zero;
            rem_reg[0][0]  <= RW'(x_mag);
            rem_reg[0][1]  <= RW'(y_mag);
            q_reg[0][0]    <= '0;
            q_reg[0][1]    <= '0;
            fits_reg[0][0] <= RW'(x_mag) < (RW'(w_mag) << DB);
            fits_reg[0][1] <= RW'(y_mag) < (RW'(w_mag) << DB);
            neg_reg[0][0]  <= x_neg || ((ZW'(x_mag) << FRAC_BITS) < ZW'(w_mag));
            neg_reg[0][1]  <= y_neg || ((ZW'(y_mag) << FRAC_BITS) < ZW'(w_mag));
        end
    end

    for (genvar s = 1; s <= DB; s++) begin : g_step
        logic [RW-1:0] trial;
        assign trial = RW'(den_reg[s-1]) << (DB - s);
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[s] <= side_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                wz_reg[s]   <= wz_reg[s-1];
                for (int l = 0; l < 2; l++) begin
                    fits_reg[s][l] <= fits_reg[s-1][l];
                    neg_reg[s][l]  <= neg_reg[s-1][l];
                    if (rem_reg[s-1][l] >= trial) begin
                        rem_reg[s][l] <= rem_reg[s-1][l] - trial;
                        q_reg[s][l]   <= q_reg[s-1][l] | (DB'(1) << (DB - s));
                    end else begin
                        rem_reg[s][l] <= rem_reg[s-1][l];
                        q_reg[s][l]   <= q_reg[s-1][l];
                    end
                end
            end
        end
    end

    always_comb begin
        kx   = q_reg[DB][0];
        ky   = q_reg[DB][1];
        in_x = fits_reg[DB][0] && (32'(kx) < 32'(HALF_X));
        in_y = fits_reg[DB][1] && (32'(ky) < 32'(HALF_Y));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_o_reg <= side_reg[DB];
            hit_reg    <= !wz_reg[DB] && in_x && in_y;
            col_reg    <= neg_reg[DB][0] ? OW_X'(HALF_X - 1 - int'(kx))
                                         : OW_X'(HALF_X + int'(kx));
            row_reg    <= neg_reg[DB][1] ? OW_Y'(HALF_Y - 1 - int'(ky))
                                         : OW_Y'(HALF_Y + int'(ky));
        end
    end

    assign ctl_out  = ctl_o_reg;
    assign side_out = side_o_reg;
    assign hit      = hit_reg;
    assign col_src  = col_reg;
    assign row_src  = row_reg;

endmodule
`default_nettype wire

>>> design/perspective_image_warp_unit.sv
// Perspective image warp unit: items pass the pw_mac stages, the pw_div entry, step
// and output registers and the frame store read register, one item per cycle sustained;
// the whole pipeline advances together and holds only while a result waits on m_ready.
// Loads travel the same pipeline and write the frame store at the stage where reads read it.
// Synchronous active-low reset clears valid bits and restores the coefficient registers;
// the frame store is not cleared.
`default_nettype none
module perspective_image_warp_unit #(
    parameter int WIDTH      = 128,
    parameter int HEIGHT     = 128,
    parameter int PIXEL_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [6:0]  s_col,
    input  logic [6:0]  s_row,
    input  logic [31:0] s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_out,
    output logic        m_in_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pw_pkg::*;

    localparam int HX    = WIDTH / 2;
    localparam int HY    = HEIGHT / 2;
    localparam int HM    = (HX > HY) ? HX : HY;
    localparam int DB    = (HM > 1) ? $clog2(HM) : 1;
    localparam int JW    = ((HM > 128) ? $clog2(HM) : 7) + 2;
    localparam int PW    = COEF_W + JW + 2;
    localparam int DEPTH = WIDTH * HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW_X  = $clog2(WIDTH);
    localparam int OW_Y  = $clog2(HEIGHT);
    localparam int SW    = 1 + AW + PIXEL_BITS;

    coef_t               coef_reg [NUM_CFG];
    logic                adv;
    ctl_t                ctl_in;
    logic [SW-1:0]       side_in;
    logic                ld_ok;
    logic [AW-1:0]       ld_addr_in;
    logic signed [JW-1:0] j, i;

    ctl_t                mac_ctl;
    logic [SW-1:0]       mac_side;
    logic [PW-1:0]       w_mag, x_mag, y_mag;
    logic                w_zero, x_neg, y_neg;

    ctl_t                div_ctl;
    logic [SW-1:0]       div_side;
    logic                div_hit;
    logic [OW_X-1:0]     col_src;
    logic [OW_Y-1:0]     row_src;

    logic                     d_ld_ok;
    logic [AW-1:0]            d_ld_addr;
    logic [PIXEL_BITS-1:0]    d_ld_pix;
    logic [AW-1:0]            rd_addr;

    logic [PIXEL_BITS-1:0]    frame_mem [DEPTH];
    logic [PIXEL_BITS-1:0]    rd_reg;
    logic                     hit_reg;
    logic                     m_valid_reg;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[REG_W_COL]   <= COEF_ZERO;
            coef_reg[REG_W_ROW]   <= COEF_ZERO;
            coef_reg[REG_W_CONST] <= COEF_ONE;
            coef_reg[REG_X_COL]   <= COEF_ONE;
            coef_reg[REG_X_ROW]   <= COEF_ZERO;
            coef_reg[REG_Y_COL]   <= COEF_ZERO;
            coef_reg[REG_Y_ROW]   <= COEF_ONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                IDX_W_COL:   coef_reg[REG_W_COL]   <= cfg_data;
                IDX_W_ROW:   coef_reg[REG_W_ROW]   <= cfg_data;
                IDX_W_CONST: coef_reg[REG_W_CONST] <= cfg_data;
                IDX_X_COL:   coef_reg[REG_X_COL]   <= cfg_data;
                IDX_X_ROW:   coef_reg[REG_X_ROW]   <= cfg_data;
                IDX_Y_COL:   coef_reg[REG_Y_COL]   <= cfg_data;
                IDX_Y_ROW:   coef_reg[REG_Y_ROW]   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // The pipeline moves as one whenever the output register is free or being emptied.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        ctl_in.valid = s_valid;
        ctl_in.op    = s_operation;
        ld_ok        = (32'(s_col) < 32'(WIDTH)) && (32'(s_row) < 32'(HEIGHT));
        ld_addr_in   = AW'(32'(s_row) * WIDTH + 32'(s_col));
        side_in      = {ld_ok, ld_addr_in, s_pixel_in[PIXEL_BITS-1:0]};
        j = $signed({{(JW-7){1'b0}}, s_col}) - $signed(JW'(HX));
        i = $signed({{(JW-7){1'b0}}, s_row}) - $signed(JW'(HY));
    end

    pw_mac #(
        .JW (JW),
        .SW (SW),
        .PW (PW)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .ctl_in   (ctl_in),
        .side_in  (side_in),
        .j        (j),
        .i        (i),
        .coef     (coef_reg),
        .ctl_out  (mac_ctl),
        .side_out (mac_side),
        .w_mag    (w_mag),
        .x_mag    (x_mag),
        .y_mag    (y_mag),
        .w_zero   (w_zero),
        .x_neg    (x_neg),
        .y_neg    (y_neg)
    );

    pw_div #(
        .PW     (PW),
        .DB     (DB),
        .HALF_X (HX),
        .HALF_Y (HY),
        .OW_X   (OW_X),
        .OW_Y   (OW_Y),
        .SW     (SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .ctl_in   (mac_ctl),
        .side_in  (mac_side),
        .w_mag    (w_mag),
        .x_mag    (x_mag),
        .y_mag    (y_mag),
        .w_zero   (w_zero),
        .x_neg    (x_neg),
        .y_neg    (y_neg),
        .ctl_out  (div_ctl),
        .side_out (div_side),
        .hit      (div_hit),
        .col_src  (col_src),
        .row_src  (row_src)
    );

    always_comb begin
        {d_ld_ok, d_ld_addr, d_ld_pix} = div_side;
        rd_addr = AW'(32'(row_src) * WIDTH + 32'(col_src));
    end

    // Frame store: loads write and reads read at the same stage, so item order holds.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (div_ctl.valid && div_ctl.op == OP_LOAD && d_ld_ok) begin
                frame_mem[d_ld_addr] <= d_ld_pix;
            end
            rd_reg  <= frame_mem[rd_addr];
            hit_reg <= div_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_ctl.valid && div_ctl.op == OP_READ;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_in_range  = hit_reg;
    assign m_pixel_out = hit_reg ? 32'(rd_reg) : 32'd0;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for perspective_image_warp_unit: loads source pixels, programs
// the warp coefficients and checks every warped read against a behavioural predictor.
// Depends on pw_pkg and the unit itself.
`default_nettype none
module tb_top;
    import pw_pkg::*;

    typedef struct {
        logic        op;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [31:0] pix;
    } pixel_item_t;

    typedef struct {
        logic [31:0] pix;
        logic        hit;
    } warp_result_t;

    localparam int  FRAME_W   = 128;
    localparam int  FRAME_H   = 128;
    localparam int  CYCLE_CAP = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready, s_operation;
    logic [6:0]  s_col, s_row;
    logic [31:0] s_pixel_in;
    logic        m_valid, m_ready, m_in_range;
    logic [31:0] m_pixel_out;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    perspective_image_warp_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_col(s_col), .s_row(s_row), .s_pixel_in(s_pixel_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_out(m_pixel_out), .m_in_range(m_in_range),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Coefficients and frame as the unit should hold them.
    longint          coef [NUM_CFG];
    logic [31:0]     frame_model [FRAME_W*FRAME_H];
    bit              loaded [FRAME_W*FRAME_H];

    pixel_item_t     pending_items[$];
    warp_result_t    expected_pixels[$];
    int              mismatches = 0;
    int              reads_checked = 0;
    int              hits_seen = 0;
    int              cycle = 0;
    bit              quiet = 0;
    bit              hold_go = 0;
    bit              hold_done = 0;
    int              hold_cnt = 0;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Nearest-neighbour index of num/den, quotient truncated to 16 fractional bits.
    function automatic longint nearest_index(longint num, longint den);
        longint unsigned an, ad, q;
        bit neg;
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q   = (an << FRAC_BITS) / ad;
        if (q != 0 && !neg) return longint'(q >> FRAC_BITS);
        if (q == 0) return -1;
        return -longint'(q >> FRAC_BITS) - 1;
    endfunction

    // Returns the frame address that a read maps to, or -1 when it falls outside.
    function automatic int source_address(logic [6:0] col, logic [6:0] row);
        longint j, i, w, x, y, n, m;
        j = longint'(col) - FRAME_W/2;
        i = longint'(row) - FRAME_H/2;
        w = coef[REG_W_COL]*j + coef[REG_W_ROW]*i + coef[REG_W_CONST];
        x = coef[REG_X_COL]*j + coef[REG_X_ROW]*i;
        y = coef[REG_Y_COL]*j + coef[REG_Y_ROW]*i;
        if (w == 0) return -1;
        n = nearest_index(x, w);
        m = nearest_index(y, w);
        if (m < -FRAME_H/2 || m >= FRAME_H/2 || n < -FRAME_W/2 || n >= FRAME_W/2) return -1;
        return int'((m + FRAME_H/2)*FRAME_W + (n + FRAME_W/2));
    endfunction

    task automatic queue_load(int col, int row, logic [31:0] pix);
        pixel_item_t it;
        it.op = OP_LOAD; it.col = col[6:0]; it.row = row[6:0]; it.pix = pix;
        loaded[row*FRAME_W + col] = 1;
        pending_items.push_back(it);
    endtask

    // A read whose source pixel was never loaded gets a load of that pixel first.
    task automatic queue_read(int col, int row);
        pixel_item_t it;
        int addr;
        addr = source_address(col[6:0], row[6:0]);
        if (addr >= 0 && !loaded[addr])
            queue_load(addr % FRAME_W, addr / FRAME_W, $urandom);
        it.op = OP_READ; it.col = col[6:0]; it.row = row[6:0]; it.pix = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_coef(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        coef[idx] = longint'(signed'(val));
        cfg_valid <= 0;
    endtask

    task automatic write_all(logic [31:0] wc, logic [31:0] wr, logic [31:0] wk,
                             logic [31:0] xc, logic [31:0] xr,
                             logic [31:0] yc, logic [31:0] yr);
        write_coef(IDX_W_COL, wc);   write_coef(IDX_W_ROW, wr);
        write_coef(IDX_W_CONST, wk); write_coef(IDX_X_COL, xc);
        write_coef(IDX_X_ROW, xr);   write_coef(IDX_Y_COL, yc);
        write_coef(IDX_Y_ROW, yr);
    endtask

    function automatic logic [31:0] small_signed(int span);
        return $urandom_range(2*span) - span;
    endfunction

    task automatic random_phase(int count);
        repeat (count) begin
            if ($urandom_range(99) < 30)
                queue_load($urandom_range(FRAME_W-1), $urandom_range(FRAME_H-1), $urandom);
            else
                queue_read($urandom_range(127), $urandom_range(127));
        end
    endtask

    // Driver: offers the oldest pending item and predicts its effect once accepted.
    always @(posedge aclk) begin
        pixel_item_t  it;
        warp_result_t r;
        int           addr;
        logic         nv;
        if (!aresetn) begin
            s_valid <= 0; s_operation <= OP_LOAD; s_col <= 0; s_row <= 0; s_pixel_in <= 0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                it = pending_items.pop_front();
                if (it.op == OP_LOAD) begin
                    frame_model[int'(it.row)*FRAME_W + int'(it.col)] = it.pix;
                end else begin
                    addr  = source_address(it.col, it.row);
                    r.hit = addr >= 0;
                    r.pix = r.hit ? frame_model[addr] : 32'd0;
                    expected_pixels.push_back(r);
                end
                nv = 0;
            end
            if (!nv && pending_items.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
                nv = 1;
                s_operation <= pending_items[0].op;
                s_col       <= pending_items[0].col;
                s_row       <= pending_items[0].row;
                s_pixel_in  <= pending_items[0].pix;
            end
            s_valid <= nv;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing into a full pipe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_go && !hold_done) begin
            hold_cnt  <= 400;
            hold_done <= 1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        warp_result_t r;
        cycle <= cycle + 1;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pixel %h in_range %b", m_pixel_out,
                                 m_in_range);
                end else begin
                    r = expected_pixels.pop_front();
                    reads_checked++;
                    if (r.hit) hits_seen++;
                    if (m_pixel_out !== r.pix || m_in_range !== r.hit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pixel exp %h got %h, in_range exp %b got %b",
                                     r.pix, m_pixel_out, r.hit, m_in_range);
                    end
                end
            end
            m_ready <= (hold_cnt == 0) && (quiet || $urandom_range(99) >= 14);
        end
        if (cycle >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        coef[REG_W_COL] = 0; coef[REG_W_ROW] = 0; coef[REG_W_CONST] = COEF_ONE;
        coef[REG_X_COL] = COEF_ONE; coef[REG_X_ROW] = 0;
        coef[REG_Y_COL] = 0; coef[REG_Y_ROW] = COEF_ONE;
        aresetn = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_operation = OP_LOAD; s_col = 0; s_row = 0; s_pixel_in = 0;
        m_ready = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // Reset coefficients: loads at three corners and the centre, some with extreme values, corner and centre reads.
        queue_load(0, 0, 32'h0000_0000);
        queue_load(127, 127, 32'hFFFF_FFFF);
        queue_load(63, 63, 32'hA5A5_5A5A);
        queue_load(127, 0, 32'h8000_0001);
        queue_read(0, 0);     queue_read(127, 127);  queue_read(64, 64);
        queue_read(127, 0);   queue_read(0, 127);    queue_read(65, 65);
        queue_read(64, 0);    queue_read(1, 1);
        wait_idle();

        // Zero divisor everywhere.
        write_all(0, 0, 0, COEF_ONE, 0, 0, COEF_ONE);
        queue_read(0, 0); queue_read(64, 64); queue_read(127, 127);
        wait_idle();

        // Extreme coefficients, both signs.
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_read(0, 0); queue_read(127, 127); queue_read(64, 64); queue_read(0, 127);
        wait_idle();
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_read(0, 0); queue_read(127, 127); queue_read(64, 64); queue_read(127, 0);
        wait_idle();

        // Mild perspective, where most reads land inside the frame; every third phase uses random coefficients.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            else
                write_all(small_signed(1 << 22), small_signed(1 << 22),
                          COEF_ONE + small_signed(1 << 28),
                          COEF_ONE + small_signed(1 << 29), small_signed(1 << 29),
                          small_signed(1 << 29), COEF_ONE + small_signed(1 << 29));
            quiet   = (ph == 4);
            hold_go = (ph == 1);
            random_phase(70);
            wait_idle();
        end

        $display("checked %0d warped reads, %0d from inside the frame, %0d mismatches",
                 reads_checked, hits_seen, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
